>>> src/ctm_pkg.sv
// shared types, opcodes and float constants for the conduction time-step block
package ctm_pkg;

    localparam int unsigned FLT_W = 32;

    typedef logic [2:0] t_op;

    localparam t_op OP_ADD  = 3'd0;
    localparam t_op OP_SUB  = 3'd1;
    localparam t_op OP_MUL  = 3'd2;
    localparam t_op OP_DIV  = 3'd3;
    localparam t_op OP_SQRT = 3'd4;

    // register indexes
    localparam logic [2:0] REG_SAT      = 3'd0;
    localparam logic [2:0] REG_TSCALE   = 3'd1;
    localparam logic [2:0] REG_COND_ON  = 3'd2;
    localparam logic [2:0] REG_LIGHT_ON = 3'd3;
    localparam logic [2:0] REG_LIGHT_T  = 3'd4;

    // request from the sequencer to the float unit
    typedef struct packed {
        logic start;
        t_op  op;
    } t_fpu_req;

    localparam logic [FLT_W-1:0] F_HALF    = 32'h3F00_0000;
    localparam logic [FLT_W-1:0] F_ONE     = 32'h3F80_0000;
    localparam logic [FLT_W-1:0] F_HUGE    = 32'h60AD_78EC;
    localparam logic [FLT_W-1:0] F_NAN_POS = 32'h7FC0_0000;
    localparam logic [FLT_W-1:0] F_NAN_DEF = 32'hFFC0_0000;

    // ordered a < b, false when either is nan
    function automatic logic flt_lt(input logic [FLT_W-1:0] a, input logic [FLT_W-1:0] b);
        logic a_nan;
        logic b_nan;
        logic both_zero;
        logic [FLT_W-1:0] ka;
        logic [FLT_W-1:0] kb;
        a_nan     = (&a[30:23]) && (|a[22:0]);
        b_nan     = (&b[30:23]) && (|b[22:0]);
        both_zero = (a[30:0] == 31'd0) && (b[30:0] == 31'd0);
        ka        = a[31] ? ~a : {1'b1, a[30:0]};
        kb        = b[31] ? ~b : {1'b1, b[30:0]};
        flt_lt    = !a_nan && !b_nan && !both_zero && (ka < kb);
    endfunction

endpackage

>>> src/conduction_timestep_min.sv
// top level: per-face conduction time-step estimate with running minimum
// Each transaction on the input stream is one cell face. Faces with a neighbour
// run through one shared float unit under a step sequencer: up to fourteen float
// operations (adds, multiplies, a square root and up to three divides). Zero,
// infinite or nan operands skip the float datapath; divide and square root
// produce one result bit per cycle, and subnormal operands are first brought to
// a leading one. A boundary face skips the float unit. On the last face, with
// conduction on, the minimum is scaled by a further multiply and the light floor
// is applied, else the result is the huge value; the result transaction is held
// on the output until taken; the input is not ready while a face is in work or
// a result is pending. Configuration writes are taken in any cycle and must only
// happen while the block is idle.
module conduction_timestep_min (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // face input: tdata = cell_temp, next_temp, cell_density, next_density
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [127:0] i_s_tdata,  // [31:0] cell_temp, [63:32] next_temp,
                                     // [95:64] cell_density, [127:96] next_density
    input  logic         i_s_tuser,  // [0] has_next
    input  logic         i_s_tlast,  // last_face
    // result output
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [31:0]  o_m_tdata,  // [31:0] timestep
    output logic         o_m_tuser,  // [0] light_limited
    // register writes
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);
    import ctm_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_ISSUE  = 3'd1;
    localparam logic [2:0] ST_WAIT   = 3'd2;
    localparam logic [2:0] ST_FINISH = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    // operand sources
    localparam logic [3:0] SRC_TC   = 4'd0;
    localparam logic [3:0] SRC_TN   = 4'd1;
    localparam logic [3:0] SRC_DC   = 4'd2;
    localparam logic [3:0] SRC_DN   = 4'd3;
    localparam logic [3:0] SRC_T    = 4'd4;
    localparam logic [3:0] SRC_RHO  = 4'd5;
    localparam logic [3:0] SRC_DT   = 4'd6;
    localparam logic [3:0] SRC_K    = 4'd7;
    localparam logic [3:0] SRC_ACC  = 4'd8;
    localparam logic [3:0] SRC_HALF = 4'd9;
    localparam logic [3:0] SRC_ONE  = 4'd10;
    localparam logic [3:0] SRC_SAT  = 4'd11;
    localparam logic [3:0] SRC_MIN  = 4'd12;
    localparam logic [3:0] SRC_TS   = 4'd13;

    // result destinations
    localparam logic [2:0] DST_ACC = 3'd0;
    localparam logic [2:0] DST_T   = 3'd1;
    localparam logic [2:0] DST_RHO = 3'd2;
    localparam logic [2:0] DST_DT  = 3'd3;
    localparam logic [2:0] DST_K   = 3'd4;

    // steps with their own follow-up
    localparam logic [3:0] STEP_KAPPA = 4'd12;
    localparam logic [3:0] STEP_EST   = 4'd13;
    localparam logic [3:0] STEP_SCALE = 4'd14;

    logic [2:0]  r_state;
    logic [3:0]  r_step;
    logic [31:0] r_tc, r_tn, r_dc, r_dn;
    logic        r_last;
    logic [31:0] r_t, r_rho, r_dt, r_k, r_acc;
    logic [31:0] r_rmin;
    logic [31:0] r_sat, r_tscale, r_light_t;
    logic        r_cond_on, r_light_on;
    logic [31:0] r_out_ts;
    logic        r_out_ll;

    // step program
    t_op        st_op;
    logic [3:0] st_a, st_b;
    logic [2:0] st_dst;

    always_comb begin
        st_op  = OP_MUL;
        st_a   = SRC_MIN;
        st_b   = SRC_TS;
        st_dst = DST_ACC;
        case (r_step)
            4'd0:  begin st_op = OP_ADD;  st_a = SRC_TC;   st_b = SRC_TN;  st_dst = DST_ACC; end
            4'd1:  begin st_op = OP_MUL;  st_a = SRC_HALF; st_b = SRC_ACC; st_dst = DST_T;   end
            4'd2:  begin st_op = OP_ADD;  st_a = SRC_DC;   st_b = SRC_DN;  st_dst = DST_ACC; end
            4'd3:  begin st_op = OP_MUL;  st_a = SRC_HALF; st_b = SRC_ACC; st_dst = DST_RHO; end
            4'd4:  begin st_op = OP_SUB;  st_a = SRC_TC;   st_b = SRC_TN;  st_dst = DST_DT;  end
            4'd5:  begin st_op = OP_MUL;  st_a = SRC_T;    st_b = SRC_T;   st_dst = DST_K;   end
            4'd6:  begin st_op = OP_SQRT; st_a = SRC_T;    st_b = SRC_T;   st_dst = DST_ACC; end
            4'd7:  begin st_op = OP_MUL;  st_a = SRC_K;    st_b = SRC_ACC; st_dst = DST_K;   end
            4'd8:  begin st_op = OP_MUL;  st_a = SRC_SAT;  st_b = SRC_T;   st_dst = DST_ACC; end
            4'd9:  begin st_op = OP_MUL;  st_a = SRC_ACC;  st_b = SRC_DT;  st_dst = DST_ACC; end
            4'd10: begin st_op = OP_DIV;  st_a = SRC_ACC;  st_b = SRC_RHO; st_dst = DST_ACC; end
            4'd11: begin st_op = OP_ADD;  st_a = SRC_ONE;  st_b = SRC_ACC; st_dst = DST_ACC; end
            4'd12: begin st_op = OP_DIV;  st_a = SRC_K;    st_b = SRC_ACC; st_dst = DST_K;   end
            4'd13: begin st_op = OP_DIV;  st_a = SRC_DC;   st_b = SRC_K;   st_dst = DST_ACC; end
            default: begin
                st_op  = OP_MUL;
                st_a   = SRC_MIN;
                st_b   = SRC_TS;
                st_dst = DST_ACC;
            end
        endcase
    end

    function automatic logic [31:0] pick(
        input logic [3:0]  sel,
        input logic [31:0] tc, input logic [31:0] tn, input logic [31:0] dc,
        input logic [31:0] dn, input logic [31:0] t, input logic [31:0] rho,
        input logic [31:0] dt, input logic [31:0] k, input logic [31:0] acc,
        input logic [31:0] sat, input logic [31:0] rmin, input logic [31:0] ts
    );
        case (sel)
            SRC_TC:   pick = tc;
            SRC_TN:   pick = tn;
            SRC_DC:   pick = dc;
            SRC_DN:   pick = dn;
            SRC_T:    pick = t;
            SRC_RHO:  pick = rho;
            SRC_DT:   pick = dt;
            SRC_K:    pick = k;
            SRC_ACC:  pick = acc;
            SRC_HALF: pick = F_HALF;
            SRC_ONE:  pick = F_ONE;
            SRC_SAT:  pick = sat;
            SRC_MIN:  pick = rmin;
            SRC_TS:   pick = ts;
            default:  pick = 32'd0;
        endcase
    endfunction

    t_fpu_req    fpu_req;
    logic [31:0] fpu_a, fpu_b, fpu_res;
    logic        fpu_done;

    always_comb begin
        fpu_req.start = (r_state == ST_ISSUE);
        fpu_req.op    = st_op;
        fpu_a = pick(st_a, r_tc, r_tn, r_dc, r_dn, r_t, r_rho, r_dt, r_k, r_acc,
                     r_sat, r_rmin, r_tscale);
        fpu_b = pick(st_b, r_tc, r_tn, r_dc, r_dn, r_t, r_rho, r_dt, r_k, r_acc,
                     r_sat, r_rmin, r_tscale);
    end

    ctm_fpu u_fpu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (fpu_req),
        .i_a     (fpu_a),
        .i_b     (fpu_b),
        .o_done  (fpu_done),
        .o_res   (fpu_res)
    );

    logic s_acc;
    logic m_acc;
    logic floor_hit;

    assign s_acc     = i_s_tvalid && o_s_tready;
    assign m_acc     = o_m_tvalid && i_m_tready;
    // light floor wins only on a strict ordered compare
    assign floor_hit = r_light_on && flt_lt(fpu_res, r_light_t);

    // register writes, out-of-range indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat      <= 32'd0;
            r_tscale   <= F_ONE;
            r_cond_on  <= 1'b0;
            r_light_on <= 1'b0;
            r_light_t  <= 32'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SAT:      r_sat      <= i_cfg_data;
                REG_TSCALE:   r_tscale   <= i_cfg_data;
                REG_COND_ON:  r_cond_on  <= i_cfg_data[0];
                REG_LIGHT_ON: r_light_on <= i_cfg_data[0];
                REG_LIGHT_T:  r_light_t  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // face sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= 4'd0;
            r_rmin  <= F_HUGE;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (s_acc) begin
                        r_tc   <= i_s_tdata[31:0];
                        r_tn   <= i_s_tdata[63:32];
                        r_dc   <= i_s_tdata[95:64];
                        r_dn   <= i_s_tdata[127:96];
                        r_last <= i_s_tlast;
                        r_step <= 4'd0;
                        r_state <= i_s_tuser ? ST_ISSUE : ST_FINISH;
                    end
                end
                ST_ISSUE: r_state <= ST_WAIT;
                ST_WAIT: begin
                    if (fpu_done) begin
                        case (st_dst)
                            DST_T:   r_t   <= fpu_res;
                            DST_RHO: r_rho <= fpu_res;
                            DST_DT:  r_dt  <= {1'b0, fpu_res[30:0]};
                            DST_K:   r_k   <= fpu_res;
                            default: r_acc <= fpu_res;
                        endcase
                        case (r_step)
                            STEP_KAPPA: begin
                                // zero conductivity gives no estimate
                                if (fpu_res[30:0] == 31'd0) begin
                                    r_state <= ST_FINISH;
                                end else begin
                                    r_step  <= r_step + 4'd1;
                                    r_state <= ST_ISSUE;
                                end
                            end
                            STEP_EST: begin
                                if (flt_lt(fpu_res, r_rmin)) begin
                                    r_rmin <= fpu_res;
                                end
                                r_state <= ST_FINISH;
                            end
                            STEP_SCALE: begin
                                r_out_ts <= floor_hit ? r_light_t : fpu_res;
                                r_out_ll <= floor_hit;
                                r_rmin   <= F_HUGE;
                                r_state  <= ST_OUT;
                            end
                            default: begin
                                r_step  <= r_step + 4'd1;
                                r_state <= ST_ISSUE;
                            end
                        endcase
                    end
                end
                ST_FINISH: begin
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (r_cond_on) begin
                        r_step  <= STEP_SCALE;
                        r_state <= ST_ISSUE;
                    end else begin
                        r_out_ts <= F_HUGE;
                        r_out_ll <= 1'b0;
                        r_rmin   <= F_HUGE;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (m_acc) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_m_tvalid  = (r_state == ST_OUT);
    assign o_m_tdata   = r_out_ts;
    assign o_m_tuser   = r_out_ll;
    assign o_cfg_ready = 1'b1;

    // no new face while a result waits
    a_no_accept_on_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("face accepted while result pending");

    // the float unit only answers while the sequencer waits for it
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fpu_done |-> (r_state == ST_WAIT))
        else $error("float result outside wait state");

    // minimum is re-armed whenever a result is presented
    a_rearmed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_rmin == F_HUGE))
        else $error("running minimum not re-armed");

    // a floored result carries the crossing time
    a_floor_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> (o_m_tdata == r_light_t))
        else $error("light floor value mismatch");

endmodule

>>> src/ctm_fpu.sv
// multi-cycle single-precision float unit: add, sub, mul, div, sqrt
module ctm_fpu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctm_pkg::t_fpu_req i_req,
    input  logic [31:0]       i_a,
    input  logic [31:0]       i_b,
    output logic              o_done,
    output logic [31:0]       o_res
);
    import ctm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRE   = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_NORM  = 3'd3;
    localparam logic [2:0] S_ROUND = 3'd4;

    logic [2:0]         r_state;
    t_op                r_op;
    logic               r_sa;
    logic               r_sb;
    logic               r_s;
    logic signed [9:0]  r_ea;
    logic signed [9:0]  r_eb;
    logic [23:0]        r_ma;
    logic [23:0]        r_mb;
    logic signed [11:0] r_x;
    logic [49:0]        r_w;
    logic [31:0]        r_rem;
    logic [26:0]        r_q;
    logic [55:0]        r_n;
    logic [4:0]         r_cnt;
    logic               r_done;
    logic [31:0]        r_res;

    // operand classes and special results
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic        b_sgn, x_sgn, is_spec;
    logic [31:0] spec;
    logic signed [9:0] ea_u, eb_u;
    logic [23:0] ma_u, mb_u;

    always_comb begin
        a_nan  = (&i_a[30:23]) && (|i_a[22:0]);
        b_nan  = (&i_b[30:23]) && (|i_b[22:0]);
        a_inf  = (&i_a[30:23]) && !(|i_a[22:0]);
        b_inf  = (&i_b[30:23]) && !(|i_b[22:0]);
        a_zero = (i_a[30:0] == 31'd0);
        b_zero = (i_b[30:0] == 31'd0);
        b_sgn  = i_b[31] ^ (i_req.op == OP_SUB);
        x_sgn  = i_a[31] ^ i_b[31];
        is_spec = 1'b1;
        spec    = F_NAN_DEF;
        case (i_req.op)
            OP_ADD, OP_SUB: begin
                if (a_nan)                 spec = i_a | 32'h0040_0000;
                else if (b_nan)            spec = i_b | 32'h0040_0000;
                else if (a_inf && b_inf)   spec = (i_a[31] == b_sgn) ? i_a : F_NAN_DEF;
                else if (a_inf)            spec = i_a;
                else if (b_inf)            spec = {b_sgn, i_b[30:0]};
                else if (a_zero && b_zero) spec = {i_a[31] & b_sgn, 31'd0};
                else if (a_zero)           spec = {b_sgn, i_b[30:0]};
                else if (b_zero)           spec = i_a;
                else                       is_spec = 1'b0;
            end
            OP_MUL: begin
                if (a_nan)                                    spec = i_a | 32'h0040_0000;
                else if (b_nan)                               spec = i_b | 32'h0040_0000;
                else if ((a_inf && b_zero) || (a_zero && b_inf)) spec = F_NAN_DEF;
                else if (a_inf || b_inf)                      spec = {x_sgn, 8'hFF, 23'd0};
                else if (a_zero || b_zero)                    spec = {x_sgn, 31'd0};
                else                                          is_spec = 1'b0;
            end
            OP_DIV: begin
                if (b_zero)              spec = (a_zero || a_nan) ? F_NAN_POS
                                                                  : {x_sgn, 8'hFF, 23'd0};
                else if (a_nan)          spec = i_a | 32'h0040_0000;
                else if (b_nan)          spec = i_b | 32'h0040_0000;
                else if (a_inf && b_inf) spec = F_NAN_DEF;
                else if (a_inf)          spec = {x_sgn, 8'hFF, 23'd0};
                else if (b_inf || a_zero) spec = {x_sgn, 31'd0};
                else                     is_spec = 1'b0;
            end
            OP_SQRT: begin
                if (a_nan || a_zero)  spec = i_a;
                else if (i_a[31])     spec = F_NAN_POS;
                else if (a_inf)       spec = i_a;
                else                  is_spec = 1'b0;
            end
            default: begin
                is_spec = 1'b1;
                spec    = F_NAN_DEF;
            end
        endcase
        ea_u = (i_a[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, i_a[30:23]});
        eb_u = (i_b[30:23] == 8'd0) ? 10'sd1 : $signed({2'b00, i_b[30:23]});
        ma_u = {|i_a[30:23], i_a[22:0]};
        mb_u = {|i_b[30:23], i_b[22:0]};
    end

    // datapath of the working cycle
    logic signed [11:0] ea_x, eb_x, el_x, sq_x;
    logic               a_big, s_l;
    logic signed [9:0]  d;
    logic [23:0]        m_l, m_s;
    logic [47:0]        wl, ws, prod;
    logic [49:0]        w_add;
    logic [24:0]        dv_diff, dv_rem_n;
    logic               dv_ge;
    logic [26:0]        dv_q_n;
    logic [31:0]        sq_cur, sq_trial, sq_rem_n;
    logic               sq_ge;
    logic [26:0]        sq_root_n;

    always_comb begin
        ea_x  = {{2{r_ea[9]}}, r_ea};
        eb_x  = {{2{r_eb[9]}}, r_eb};
        sq_x  = (ea_x >>> 1) + 12'sd65;
        a_big = (r_ea > r_eb) || ((r_ea == r_eb) && (r_ma >= r_mb));
        m_l   = a_big ? r_ma : r_mb;
        m_s   = a_big ? r_mb : r_ma;
        s_l   = a_big ? r_sa : r_sb;
        el_x  = a_big ? ea_x : eb_x;
        d     = a_big ? (r_ea - r_eb) : (r_eb - r_ea);
        wl    = {m_l, 24'd0};
        ws    = (d > 10'sd24) ? 48'd1 : ({m_s, 24'd0} >> d[4:0]);
        w_add = (r_sa == r_sb) ? ({2'b00, wl} + {2'b00, ws}) : ({2'b00, wl} - {2'b00, ws});
        prod  = r_ma * r_mb;

        dv_diff  = r_rem[24:0] - {1'b0, r_mb};
        dv_ge    = r_rem[24:0] >= {1'b0, r_mb};
        dv_rem_n = {(dv_ge ? dv_diff[23:0] : r_rem[23:0]), 1'b0};
        dv_q_n   = {r_q[25:0], dv_ge};

        sq_cur    = {r_rem[29:0], r_n[55:54]};
        sq_trial  = {3'b000, r_q, 2'b01};
        sq_ge     = sq_cur >= sq_trial;
        sq_rem_n  = sq_ge ? (sq_cur - sq_trial) : sq_cur;
        sq_root_n = {r_q[25:0], sq_ge};
    end

    // round to nearest even
    logic               rnd_up;
    logic [24:0]        sig_sum;
    logic [23:0]        sig24;
    logic signed [11:0] x_r;
    logic [31:0]        rnd_res;

    always_comb begin
        rnd_up  = r_w[24] & ((|r_w[23:0]) | r_w[25]);
        sig_sum = {1'b0, r_w[48:25]} + {24'd0, rnd_up};
        sig24   = sig_sum[24] ? sig_sum[24:1] : sig_sum[23:0];
        x_r     = sig_sum[24] ? (r_x + 12'sd1) : r_x;
        rnd_res = (x_r >= 12'sd255) ? {r_s, 8'hFF, 23'd0}
                                    : {r_s, (sig24[23] ? x_r[7:0] : 8'h00), sig24[22:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_req.start) begin
                        r_op <= i_req.op;
                        if (is_spec) begin
                            r_res  <= spec;
                            r_done <= 1'b1;
                        end else begin
                            r_sa    <= i_a[31];
                            r_sb    <= b_sgn;
                            r_ea    <= ea_u;
                            r_eb    <= eb_u;
                            r_ma    <= ma_u;
                            r_mb    <= mb_u;
                            r_state <= S_PRE;
                        end
                    end
                end
                S_PRE: begin
                    // subnormal operands are brought to a leading one
                    if (!r_ma[23]) begin
                        r_ma <= {r_ma[22:0], 1'b0};
                        r_ea <= r_ea - 10'sd1;
                    end
                    if (!r_mb[23] && (r_op != OP_SQRT)) begin
                        r_mb <= {r_mb[22:0], 1'b0};
                        r_eb <= r_eb - 10'sd1;
                    end
                    if (r_ma[23] && (r_mb[23] || (r_op == OP_SQRT))) begin
                        r_cnt   <= 5'd0;
                        r_q     <= 27'd0;
                        r_rem   <= (r_op == OP_DIV) ? {8'd0, r_ma} : 32'd0;
                        r_n     <= r_ea[0] ? {3'b000, r_ma, 29'd0} : {4'b0000, r_ma, 28'd0};
                        r_x     <= sq_x;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    case (r_op)
                        OP_ADD, OP_SUB: begin
                            if (w_add == 50'd0) begin
                                r_res   <= 32'd0;
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                r_w     <= w_add;
                                r_x     <= el_x + 12'sd1;
                                r_s     <= s_l;
                                r_state <= S_NORM;
                            end
                        end
                        OP_MUL: begin
                            r_w     <= {2'b00, prod};
                            r_x     <= ea_x + eb_x - 12'sd125;
                            r_s     <= r_sa ^ r_sb;
                            r_state <= S_NORM;
                        end
                        OP_DIV: begin
                            r_rem <= {7'd0, dv_rem_n};
                            r_q   <= dv_q_n;
                            r_cnt <= r_cnt + 5'd1;
                            if (r_cnt == 5'd25) begin
                                r_w     <= {1'b0, dv_q_n[25:0], 22'd0, |dv_rem_n};
                                r_x     <= ea_x - eb_x + 12'sd127;
                                r_s     <= r_sa ^ r_sb;
                                r_state <= S_NORM;
                            end
                        end
                        OP_SQRT: begin
                            r_rem <= sq_rem_n;
                            r_q   <= sq_root_n;
                            r_n   <= {r_n[53:0], 2'b00};
                            r_cnt <= r_cnt + 5'd1;
                            if (r_cnt == 5'd27) begin
                                r_w     <= {2'b00, sq_root_n, 20'd0, |sq_rem_n};
                                r_s     <= 1'b0;
                                r_state <= S_NORM;
                            end
                        end
                        default: begin
                            r_res   <= F_NAN_DEF;
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_NORM: begin
                    // one bit per cycle, sticky kept in the lowest bit
                    if (r_w[49]) begin
                        r_w <= {1'b0, r_w[49:2], r_w[1] | r_w[0]};
                        r_x <= r_x + 12'sd1;
                    end else if (r_x < -12'sd60) begin
                        r_w <= {49'd0, |r_w};
                        r_x <= 12'sd1;
                    end else if (!r_w[48] && (r_x > 12'sd1)) begin
                        r_w <= {r_w[48:0], 1'b0};
                        r_x <= r_x - 12'sd1;
                    end else if (r_x < 12'sd1) begin
                        r_w <= {1'b0, r_w[49:2], r_w[1] | r_w[0]};
                        r_x <= r_x + 12'sd1;
                    end else begin
                        r_state <= S_ROUND;
                    end
                end
                S_ROUND: begin
                    r_res   <= rnd_res;
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> sim/tb_conduction_timestep_min.sv
// self-checking testbench for the conduction time-step minimum block
module tb_conduction_timestep_min;
    timeunit 1ns;
    timeprecision 1ps;

    import ctm_pkg::*;

    // longest face in work plus subnormal pre-normalization, with margin
    localparam int SETTLE_CYCLES = 1200;
    localparam int RANDOM_ITEMS  = 600;

    typedef struct {
        logic [31:0] cell_temp;
        logic [31:0] next_temp;
        logic [31:0] cell_density;
        logic [31:0] next_density;
        logic        has_next;
        logic        last_face;
    } t_face_in;

    typedef struct {
        logic [31:0] timestep;
        logic        light_limited;
    } t_step_out;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [127:0] i_s_tdata;
    logic         i_s_tuser;
    logic         i_s_tlast;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [31:0]  o_m_tdata;
    logic         o_m_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    conduction_timestep_min dut (.*);

    // predictor copy of the registers and the running minimum
    logic [31:0] sat_factor_q;
    logic [31:0] time_scale_q;
    logic        cond_on_q;
    logic        light_on_q;
    logic [31:0] light_time_q;
    logic [31:0] min_step_q;

    t_face_in  pending_faces[$];
    t_step_out expected_steps[$];
    t_face_in  cur_face;
    int    send_gap;
    int    recv_gap;
    int    err_count;
    int    faces_sent;
    int    steps_checked;
    int    limited_seen;
    int    phase_count;

    // ------------------------------------------------------------------
    // float32 arithmetic through doubles: one rounding of the exact-enough
    // double result gives the correctly rounded single result
    // ------------------------------------------------------------------
    function automatic logic is_nan(input logic [31:0] b);
        return (&b[30:23]) && (|b[22:0]);
    endfunction

    function automatic real to_real(input logic [31:0] b);
        logic [63:0] d;
        int          e;
        logic [22:0] f;
        e = b[30:23];
        f = b[22:0];
        if (e == 255) begin
            d = {b[31], 11'h7FF, f, 29'd0};
        end else if (e == 0 && f == 0) begin
            d = {b[31], 63'd0};
        end else begin
            if (e == 0) begin
                // subnormal: normalize and drop the leading one
                e = 1;
                while (!f[22]) begin
                    f = f << 1;
                    e--;
                end
                f = f << 1;
                e--;
            end
            d = {b[31], 11'(e + 896), f, 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    function automatic logic [31:0] to_single(input real x);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] q;
        logic [63:0] rem;
        logic [63:0] half;
        int          fe;
        int          sh;
        d = $realtobits(x);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? F_NAN_POS : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 11'd0)
            return {d[63], 31'd0};
        fe  = int'(d[62:52]) - 896;
        sig = {11'd0, 1'b1, d[51:0]};
        sh  = (fe >= 1) ? 29 : 30 - fe;
        if (sh > 60)
            return {d[63], 31'd0};
        q    = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0]))
            q++;
        if (fe >= 1) begin
            if (q[24]) begin
                q  = q >> 1;
                fe++;
            end
            if (fe >= 255)
                return {d[63], 8'hFF, 23'd0};
            return {d[63], 8'(fe), q[22:0]};
        end
        // subnormal, a carry into bit 23 lands on the smallest normal
        return {d[63], q[30:0]};
    endfunction

    function automatic logic [31:0] f_add(input logic [31:0] a, input logic [31:0] b);
        return to_single(to_real(a) + to_real(b));
    endfunction

    function automatic logic [31:0] f_sub(input logic [31:0] a, input logic [31:0] b);
        return to_single(to_real(a) - to_real(b));
    endfunction

    function automatic logic [31:0] f_mul(input logic [31:0] a, input logic [31:0] b);
        return to_single(to_real(a) * to_real(b));
    endfunction

    function automatic logic [31:0] f_div(input logic [31:0] a, input logic [31:0] b);
        if (b[30:0] == 31'd0) begin
            if (a[30:0] == 31'd0 || is_nan(a))
                return F_NAN_POS;
            return {a[31] ^ b[31], 8'hFF, 23'd0};
        end
        return to_single(to_real(a) / to_real(b));
    endfunction

    function automatic logic [31:0] f_sqrt(input logic [31:0] a);
        if (is_nan(a) || a[30:0] == 31'd0)
            return a;
        if (a[31])
            return F_NAN_POS;
        return to_single($sqrt(to_real(a)));
    endfunction

    // one face: update the minimum, and on the last face return the step
    function automatic logic apply_face(input t_face_in fc, output t_step_out res);
        logic [31:0] t_face;
        logic [31:0] rho;
        logic [31:0] dtemp;
        logic [31:0] kappa;
        logic [31:0] sat;
        logic [31:0] est;
        logic [31:0] step;
        res = '{timestep: 32'd0, light_limited: 1'b0};
        if (fc.has_next) begin
            t_face = f_mul(F_HALF, f_add(fc.cell_temp, fc.next_temp));
            rho    = f_mul(F_HALF, f_add(fc.cell_density, fc.next_density));
            dtemp  = f_sub(fc.cell_temp, fc.next_temp) & 32'h7FFF_FFFF;
            kappa  = f_mul(f_mul(t_face, t_face), f_sqrt(t_face));
            sat    = f_div(f_mul(f_mul(sat_factor_q, t_face), dtemp), rho);
            kappa  = f_div(kappa, f_add(F_ONE, sat));
            // zero conductivity gives no estimate; nan never wins the compare
            if (kappa[30:0] != 31'd0) begin
                est = f_div(fc.cell_density, kappa);
                if (to_real(est) < to_real(min_step_q))
                    min_step_q = est;
            end
        end
        if (!fc.last_face)
            return 1'b0;
        step = F_HUGE;
        if (cond_on_q) begin
            step = f_mul(min_step_q, time_scale_q);
            if (light_on_q && to_real(light_time_q) > to_real(step)) begin
                step              = light_time_q;
                res.light_limited = 1'b1;
            end
        end
        res.timestep = step;
        min_step_q   = F_HUGE;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // clock, reset and timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // face driver: pops pending faces, random gap before each transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_step_out res;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap   <= 0;
        end else if (i_s_tvalid && o_s_tready) begin
            // accepted: predict now, with the registers of this phase
            if (apply_face(cur_face, res))
                expected_steps.push_back(res);
            faces_sent++;
            if ($urandom_range(0, 2) == 0 && pending_faces.size() > 0) begin
                // back-to-back: keep valid high for the next face
                cur_face = pending_faces.pop_front();
                i_s_tdata <= {cur_face.next_density, cur_face.cell_density,
                              cur_face.next_temp, cur_face.cell_temp};
                i_s_tuser <= cur_face.has_next;
                i_s_tlast <= cur_face.last_face;
            end else begin
                i_s_tvalid <= 1'b0;
                send_gap   <= $urandom_range(0, 14);
            end
        end else if (!i_s_tvalid) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
            end else if (pending_faces.size() > 0) begin
                cur_face = pending_faces.pop_front();
                i_s_tdata  <= {cur_face.next_density, cur_face.cell_density,
                               cur_face.next_temp, cur_face.cell_temp};
                i_s_tuser  <= cur_face.has_next;
                i_s_tlast  <= cur_face.last_face;
                i_s_tvalid <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // result monitor: random stall after each transaction, compares fields
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_step_out want;
        int        stall;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            recv_gap   <= 0;
        end else if (o_m_tvalid && i_m_tready) begin
            if (expected_steps.size() == 0) begin
                $error("result transaction with none expected: timestep %h", o_m_tdata);
                err_count++;
            end else begin
                want = expected_steps.pop_front();
                if (o_m_tdata !== want.timestep) begin
                    $error("timestep: expected %h actual %h", want.timestep, o_m_tdata);
                    err_count++;
                end
                if (o_m_tuser !== want.light_limited) begin
                    $error("light_limited: expected %b actual %b",
                           want.light_limited, o_m_tuser);
                    err_count++;
                end
                limited_seen += want.light_limited;
            end
            steps_checked++;
            stall = $urandom_range(0, 14);
            // long stretches of a ready sink
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            i_m_tready <= (stall == 0);
            recv_gap   <= stall;
        end else if (recv_gap > 0) begin
            recv_gap   <= recv_gap - 1;
            i_m_tready <= (recv_gap == 1);
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            REG_SAT:      sat_factor_q = val;
            REG_TSCALE:   time_scale_q = val;
            REG_COND_ON:  cond_on_q    = val[0];
            REG_LIGHT_ON: light_on_q   = val[0];
            REG_LIGHT_T:  light_time_q = val;
            default: ;
        endcase
        // pause with valid low before the next register transaction
        @(posedge i_clk);
    endtask

    task automatic write_all(input logic [31:0] sat, input logic [31:0] scale,
                             input logic cond, input logic light,
                             input logic [31:0] lct);
        write_reg(REG_SAT, sat);
        write_reg(REG_TSCALE, scale);
        write_reg(REG_COND_ON, {31'd0, cond});
        write_reg(REG_LIGHT_ON, {31'd0, light});
        write_reg(REG_LIGHT_T, lct);
    endtask

    // pause the sender until every result is in and the last face has drained
    task automatic drain();
        do @(posedge i_clk);
        while (pending_faces.size() != 0 || i_s_tvalid || expected_steps.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        phase_count++;
    endtask

    task automatic push_face(input logic [31:0] tc, input logic [31:0] tn,
                             input logic [31:0] dc, input logic [31:0] dn,
                             input logic nxt, input logic lst);
        t_face_in fc;
        fc = '{cell_temp: tc, next_temp: tn, cell_density: dc, next_density: dn,
               has_next: nxt, last_face: lst};
        pending_faces.push_back(fc);
    endtask

    // plausible positive values across a wide exponent band
    function automatic logic [31:0] plain_float();
        return {1'b0, 8'($urandom_range(100, 160)), 23'($urandom)};
    endfunction

    // any pattern: specials, subnormals, extremes or raw bits
    function automatic logic [31:0] odd_float();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return {1'($urandom), 8'hFF, 23'd0};
            3: return {1'($urandom), 8'hFF, 23'($urandom) | 23'd1};
            4: return {1'($urandom), 8'd0, 23'($urandom)};
            5: return {1'($urandom), 31'h7F7F_FFFF};
            6: return {1'b1, 8'($urandom_range(100, 160)), 23'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    task automatic random_faces(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) < 85)
                push_face(plain_float(), plain_float(), plain_float(), plain_float(),
                          $urandom_range(0, 19) != 0, $urandom_range(0, 9) == 0);
            else
                push_face(odd_float(), odd_float(), odd_float(), odd_float(),
                          1'($urandom), $urandom_range(0, 9) == 0);
        end
        // close the sweep so every phase ends on a result
        push_face(plain_float(), plain_float(), plain_float(), plain_float(), 1'b1, 1'b1);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_s_tlast   = 1'b0;
        i_m_tready  = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_SAT;
        i_cfg_data  = '0;
        err_count     = 0;
        faces_sent    = 0;
        steps_checked = 0;
        limited_seen  = 0;
        phase_count   = 0;
        sat_factor_q  = 32'd0;
        time_scale_q  = F_ONE;
        cond_on_q     = 1'b0;
        light_on_q    = 1'b0;
        light_time_q  = 32'd0;
        min_step_q    = F_HUGE;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset registers: conduction off, every result is the huge value
        push_face(32'h4B18_9680, 32'h4B00_0000, 32'h3F80_0000, 32'h3F00_0000, 1'b1, 1'b1);
        push_face(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1);
        drain();

        // directed faces with conduction on
        write_all(32'h3A83_126F, F_ONE, 1'b1, 1'b0, 32'd0);
        push_face(32'h4B18_9680, 32'h4B00_0000, 32'h3F80_0000, 32'h3F00_0000, 1'b1, 1'b0);
        // boundary face carries no estimate
        push_face(32'h3F80_0000, 32'h3F80_0000, 32'h0000_0001, 32'h0000_0001, 1'b0, 1'b1);
        // zero conductivity on a last face: a sweep with no estimate at all
        push_face(32'h0000_0000, 32'h8000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1);
        // temperature overflow, negative temperature, nan temperature
        push_face(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1, 1'b0);
        push_face(32'hC2C8_0000, 32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b0);
        push_face(32'h7FC0_0001, 32'h4000_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1);
        // subnormal operands, zero and negative density, infinite inputs
        push_face(32'h0000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0000_0003, 1'b1, 1'b0);
        push_face(32'h4120_0000, 32'h4100_0000, 32'h0000_0000, 32'h3F80_0000, 1'b1, 1'b0);
        push_face(32'h4120_0000, 32'h4100_0000, 32'hBF80_0000, 32'h3F80_0000, 1'b1, 1'b1);
        push_face(32'h7F80_0000, 32'h3F80_0000, 32'h7F80_0000, 32'hFF80_0000, 1'b1, 1'b0);
        push_face(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
        drain();

        // light floor on: infinite floor always wins, nan floor never does
        write_all(32'h0000_0000, 32'h0000_0001, 1'b1, 1'b1, 32'h7F80_0000);
        push_face(32'h4B18_9680, 32'h4B00_0000, 32'h3F80_0000, 32'h3F00_0000, 1'b1, 1'b1);
        push_face(32'h4120_0000, 32'h4100_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0, 1'b1);
        drain();
        write_reg(REG_LIGHT_T, 32'hFFFF_FFFF);
        write_reg(REG_SAT, 32'h7F7F_FFFF);
        write_reg(REG_TSCALE, 32'h7F7F_FFFF);
        push_face(32'h4B18_9680, 32'h4B00_0000, 32'h3F80_0000, 32'h3F00_0000, 1'b1, 1'b1);
        push_face(32'h4120_0000, 32'h4100_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b1, 1'b1);
        drain();

        // random phases over a spread of register settings
        write_all(32'h3A83_126F, 32'h3E80_0000, 1'b1, 1'b0, 32'd0);
        random_faces(RANDOM_ITEMS / 6);
        drain();
        write_all(32'h0000_0000, 32'h7F7F_FFFF, 1'b1, 1'b1, 32'h3F80_0000);
        random_faces(RANDOM_ITEMS / 6);
        drain();
        write_all(32'h7F7F_FFFF, 32'h0000_0001, 1'b1, 1'b1, 32'h0000_0000);
        random_faces(RANDOM_ITEMS / 6);
        drain();
        write_all($urandom, 32'h3F80_0000, 1'b0, 1'b1, $urandom);
        random_faces(RANDOM_ITEMS / 12);
        drain();
        write_all({2'b00, 30'($urandom)}, {2'b00, 30'($urandom) | 30'd1}, 1'b1, 1'b1,
                  plain_float());
        random_faces(RANDOM_ITEMS / 4);
        drain();
        write_all(32'h3C23_D70A, F_ONE, 1'b1, 1'b1, 32'hFFFF_FFFF);
        random_faces(RANDOM_ITEMS / 6);
        drain();

        $display("faces sent %0d, results checked %0d (%0d light-limited), phases %0d",
                 faces_sent, steps_checked, limited_seen, phase_count);
        $display("covered conduction off/on, light floor on/off, extreme scales and specials");
        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
